// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FUC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define FUC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/fuc_pkg.sv
`default_nettype none
package fuc_pkg;

  localparam int FRAME_WORDS = 256;
  localparam int SLOT_W      = $clog2(FRAME_WORDS);
  localparam int WORD_W      = 16;
  localparam int INDEX_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int SLOT_OUT_W  = 8;

  localparam logic [WORD_W-1:0] HEADER_MASK = 16'hfe00;
  localparam logic [WORD_W-1:0] DATA_MASK   = 16'h01ff;

  localparam logic EVT_UPSET  = 1'b0;
  localparam logic EVT_LENGTH = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               code;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
    logic [SLOT_W-1:0]  slot;
  } stage_t;

  typedef struct packed {
    logic                  code;
    logic [INDEX_W-1:0]    index;
    logic [WORD_W-1:0]     stored;
    logic [WORD_W-1:0]     arrived;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    upsets;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/frame_upset_compare.sv
// Datapath: an accepted word goes into the stage register as the reference RAM read is
// registered; the compare result beat then goes into the output buffer's head or skid.
// Throughput: one word per cycle while the output buffer has space; the reference RAM
// is read and rewritten at the same slot in the accept cycle, so it needs no interlock.
// Reset (synchronous, rst_n low) returns to seeking the first header and clears the
// counters; the reference RAM is not cleared, since every compared slot is filled first.
`default_nettype none
module frame_upset_compare (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [fuc_pkg::WORD_W-1:0]     in_data_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_event_code,
  output logic      [fuc_pkg::INDEX_W-1:0]    out_stream_index,
  output logic      [fuc_pkg::WORD_W-1:0]     out_stored_word,
  output logic      [fuc_pkg::WORD_W-1:0]     out_arrived_word,
  output logic      [fuc_pkg::SLOT_OUT_W-1:0] out_slot_number,
  output logic      [fuc_pkg::COUNT_W-1:0]    out_upsets_so_far
);
  import fuc_pkg::*;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  stage_t            stage;
  logic              res_valid;
  result_t           res;
  result_t           out_beat;
  logic [1:0]        space;

  assign in_ready = space > {1'b0, stage.valid};

  fuc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .stage        (stage)
  );

  fuc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAME_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fuc_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  fuc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (res_valid),
    .enq       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .space     (space)
  );

  assign out_event_code    = out_beat.code;
  assign out_stream_index  = out_beat.index;
  assign out_stored_word   = out_beat.stored;
  assign out_arrived_word  = out_beat.arrived;
  assign out_slot_number   = out_beat.slot;
  assign out_upsets_so_far = out_beat.upsets;

endmodule
`default_nettype wire

// File: rtl/fuc_ram.sv
`default_nettype none
module fuc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: the read returns the entry as it was before this cycle's write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/fuc_seq.sv
`default_nettype none
module fuc_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [fuc_pkg::WORD_W-1:0]    in_data_word,
  output logic                               ram_we,
  output logic      [fuc_pkg::SLOT_W-1:0]    ram_addr,
  output logic      [fuc_pkg::WORD_W-1:0]    ram_wdata,
  output fuc_pkg::stage_t                    stage
);
  import fuc_pkg::*;

  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_FILL = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_CMP  = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_WORDS - 1);

  logic [1:0]         phase_r, phase_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  dist_r, dist_nxt;
  logic [INDEX_W-1:0] pos_r, pos_nxt;
  stage_t             stage_r, stage_nxt;

  logic              acc;
  logic              is_hdr;
  logic              slot_last;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] dist_inc;

  always_comb begin
    acc       = in_valid & in_ready;
    is_hdr    = (in_data_word & HEADER_MASK) == HEADER_MASK;
    slot_last = slot_r == SLOT_LAST;
    slot_inc  = slot_last ? '0 : slot_r + 1'b1;
    dist_inc  = (dist_r == SLOT_LAST) ? '0 : dist_r + 1'b1;

    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    dist_nxt  = dist_r;
    pos_nxt   = pos_r;
    ram_we    = 1'b0;

    stage_nxt.valid = 1'b0;
    stage_nxt.code  = EVT_UPSET;
    stage_nxt.index = pos_r;
    stage_nxt.word  = in_data_word;
    stage_nxt.slot  = slot_r;

    if (acc) begin
      pos_nxt = pos_r + 1'b1;
      case (phase_r)
        PH_SEEK: begin
          if (is_hdr) begin
            ram_we    = 1'b1;
            dist_nxt  = '0;
            slot_nxt  = SLOT_W'(1);
            phase_nxt = PH_FILL;
          end
        end
        PH_FILL: begin
          dist_nxt = dist_inc;
          ram_we   = 1'b1;
          slot_nxt = slot_inc;
          if (slot_last) begin
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          dist_nxt = dist_inc;
          if (is_hdr) begin
            ram_we          = 1'b1;
            slot_nxt        = SLOT_W'(1);
            phase_nxt       = PH_CMP;
            stage_nxt.valid = dist_inc != '0;
            stage_nxt.code  = EVT_LENGTH;
          end
        end
        PH_CMP: begin
          dist_nxt        = dist_inc;
          ram_we          = 1'b1;
          stage_nxt.valid = 1'b1;
          slot_nxt        = slot_inc;
          if (slot_last) begin
            phase_nxt = PH_WAIT;
          end
        end
        default: begin
          phase_nxt = PH_SEEK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEEK;
      slot_r        <= '0;
      dist_r        <= '0;
      pos_r         <= '0;
      stage_r.valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      dist_r  <= dist_nxt;
      pos_r   <= pos_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign ram_addr  = slot_r;
  assign ram_wdata = in_data_word;
  assign stage     = stage_r;

endmodule
`default_nettype wire

// File: rtl/fuc_cmp.sv
`default_nettype none
module fuc_cmp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fuc_pkg::stage_t            stage,
  input  wire logic [fuc_pkg::WORD_W-1:0] ram_rdata,
  output logic                            res_valid,
  output fuc_pkg::result_t                res
);
  import fuc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               mismatch;
  logic [31:0]        slot_wide;

  always_comb begin
    mismatch  = (stage.code == EVT_UPSET) &&
                ((stage.word & DATA_MASK) != (ram_rdata & DATA_MASK));
    count_nxt = count_r;
    if (stage.valid && mismatch && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
    slot_wide = 32'(stage.slot);

    res_valid   = stage.valid && ((stage.code == EVT_LENGTH) || mismatch);
    res.code    = stage.code;
    res.index   = stage.index;
    res.stored  = (stage.code == EVT_LENGTH) ? '0 : ram_rdata;
    res.arrived = stage.word;
    res.slot    = (stage.code == EVT_LENGTH) ? '0 : slot_wide[SLOT_OUT_W-1:0];
    res.upsets  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fuc_obuf.sv
`default_nettype none
module fuc_obuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              enq_valid,
  input  wire fuc_pkg::result_t  enq,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output fuc_pkg::result_t       out_beat,
  output logic [1:0]             space
);
  import fuc_pkg::*;

  result_t head_r, skid_r;
  logic    head_vld_r, skid_vld_r;
  logic    pop;

  assign pop = head_vld_r & out_ready;

  // The skid entry takes a beat while the head entry is stalled, or when it refills as its own beat moves to the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        head_r     <= skid_r;
        skid_r     <= enq;
        skid_vld_r <= enq_valid;
      end else begin
        head_r     <= enq;
        head_vld_r <= enq_valid;
      end
    end else if (!head_vld_r) begin
      head_r     <= enq;
      head_vld_r <= enq_valid;
    end else if (enq_valid) begin
      skid_r     <= enq;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_valid = head_vld_r;
  assign out_beat  = head_r;
  assign space     = 2'd2 - {1'b0, head_vld_r} - {1'b0, skid_vld_r} + {1'b0, pop};

endmodule
`default_nettype wire

// File: rtl/fuc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fuc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [fuc_pkg::WORD_W-1:0]     in_data_word,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           out_event_code,
  input wire logic [fuc_pkg::INDEX_W-1:0]    out_stream_index,
  input wire logic [fuc_pkg::WORD_W-1:0]     out_stored_word,
  input wire logic [fuc_pkg::WORD_W-1:0]     out_arrived_word,
  input wire logic [fuc_pkg::SLOT_OUT_W-1:0] out_slot_number,
  input wire logic [fuc_pkg::COUNT_W-1:0]    out_upsets_so_far
);
  import fuc_pkg::*;

  `FUC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
    in_valid && $stable(in_data_word))

  `FUC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_stream_index) && $stable(out_arrived_word) &&
    $stable(out_stored_word) && $stable(out_upsets_so_far))

  `FUC_ASSERT_NOW(a_length_fields, clk, rst_n, out_valid && (out_event_code == EVT_LENGTH),
    (out_stored_word == '0) && (out_slot_number == '0))

  `FUC_ASSERT_NOW(a_length_header, clk, rst_n, out_valid && (out_event_code == EVT_LENGTH),
    (out_arrived_word & HEADER_MASK) == HEADER_MASK)

  `FUC_ASSERT_NOW(a_upset_real, clk, rst_n, out_valid && (out_event_code == EVT_UPSET),
    ((out_arrived_word & DATA_MASK) != (out_stored_word & DATA_MASK)) &&
    (out_upsets_so_far != '0))

endmodule

bind frame_upset_compare fuc_checker u_fuc_checker (.*);
`default_nettype wire
